// ===== src/voxel_ray_traversal_stepper_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the voxel ray traversal stepper
// Implication checks in same-cycle and next-cycle form.
// ---------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_STEPPER_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_STEPPER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VRTS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VRTS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vrts_pkg.sv =====
// ---------------------------------------------------------------------------
// vrts_pkg
// Shared widths, codes and item types of the voxel ray traversal stepper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrts_pkg;

  localparam int FRAC_BITS     = 16;  // fraction bits of an origin coordinate
  localparam int DIR_FRAC_BITS = 14;  // fraction bits of a direction component
  localparam int ORIGIN_W      = 32;
  localparam int DIR_W         = 16;
  localparam int CELL_W        = 16;
  localparam int CROSS_W       = 32;
  localparam int REACH_W       = 15;
  localparam int FACE_W        = 3;

  // dividend is at most 1.0 in Q.FRAC_BITS shifted up by DIR_FRAC_BITS
  localparam int DIV_NUM_W = FRAC_BITS + 1 + DIR_FRAC_BITS;
  localparam int DIV_DEN_W = DIR_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // six divisions per start: span and first crossing for x, y, z
  localparam int DIV_COUNT = 6;
  localparam int DIV_SEL_W = $clog2(DIV_COUNT);

  localparam logic [CROSS_W-1:0] CROSS_INF   = '1;
  localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(500);

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } command_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_LEFT  = 3'd0,
    FACE_RIGHT = 3'd1,
    FACE_BACK  = 3'd2,
    FACE_FRONT = 3'd3,
    FACE_UP    = 3'd4,
    FACE_DOWN  = 3'd5,
    FACE_NONE  = 3'd6
  } face_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_REPORT
  } ctrl_state_t;

  typedef struct packed {
    logic                       command;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic signed [ORIGIN_W-1:0] origin_z;
    logic signed [DIR_W-1:0]    dir_x;
    logic signed [DIR_W-1:0]    dir_y;
    logic signed [DIR_W-1:0]    dir_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_x;
    logic signed [CELL_W-1:0] cell_y;
    logic signed [CELL_W-1:0] cell_z;
    logic [FACE_W-1:0]        entered_face;
    logic                     out_of_range;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                 load_in;
    logic                 div_go;
    logic                 div_write;
    logic [DIV_SEL_W-1:0] div_sel;   // bit 0: 0 span, 1 crossing; upper bits: axis
    logic                 step;
    logic                 report;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_start;
    logic out_free;
    logic div_done;
  } dp_status_t;

endpackage

// ===== src/vrts_div.sv =====
// ---------------------------------------------------------------------------
// vrts_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrts_div import vrts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] work;   // dividend bits shift out, quotient bits shift in

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem, work[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (go) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      work <= dividend;
      den  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      if (fits) begin
        rem  <= diff[DIV_DEN_W-1:0];
        work <= {work[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DIV_DEN_W-1:0];
        work <= {work[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = work;

endmodule

// ===== src/vrts_ctrl.sv =====
// ---------------------------------------------------------------------------
// vrts_ctrl
// Sequencer: item intake, division sequence of a start, result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "voxel_ray_traversal_stepper_assert.svh"

module vrts_ctrl import vrts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t          state, state_next;
  logic [DIV_SEL_W-1:0] div_sel, div_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_sel <= '0;
    end else begin
      state   <= state_next;
      div_sel <= div_sel_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_sel_next  = div_sel;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.div_sel   = div_sel;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = status.in_is_start ? ST_DIV_GO : ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (status.out_free) begin
          cmd.step   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_write = 1'b1;
          if (div_sel == DIV_SEL_W'(DIV_COUNT - 1)) begin
            div_sel_next = '0;
            state_next   = ST_REPORT;
          end else begin
            div_sel_next = div_sel + 1'b1;
            state_next   = ST_DIV_GO;
          end
        end
      end
      ST_REPORT: begin
        if (status.out_free) begin
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `VRTS_ASSERT_NOW(a_sel_range, clk, rst, 1'b1, div_sel <= DIV_SEL_W'(DIV_COUNT - 1), "division index out of range")
  `VRTS_ASSERT_NEXT(a_start_divides, clk, rst, in_valid && in_ready && status.in_is_start, state == ST_DIV_GO, "start did not begin divisions")
  `VRTS_ASSERT_NOW(a_done_expected, clk, rst, status.div_done, state == ST_DIV_WAIT, "divider finished while not awaited")

endmodule

// ===== src/vrts_datapath.sv =====
// ---------------------------------------------------------------------------
// vrts_datapath
// Ray state, divider operand select, step logic and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "voxel_ray_traversal_stepper_assert.svh"

module vrts_datapath import vrts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  in_item_t           in_data,
  input  logic               out_ready,
  input  logic               cfg_wen,
  input  logic [REACH_W-1:0] cfg_wdata,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  output logic               out_valid,
  output out_item_t          out_data
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  in_item_t           in_reg;
  logic [REACH_W-1:0] reach_limit;

  logic [CELL_W-1:0]  cur_cell   [3];
  logic [CROSS_W-1:0] next_cross [3];
  logic [CROSS_W-1:0] cell_span  [3];
  logic [1:0]         step_sign  [3];
  logic               finished;

  // ---- divider operands for the axis under division ----
  axis_t                div_axis;
  logic [ORIGIN_W-1:0]  org;
  logic [DIR_W-1:0]     dir;
  logic [DIV_DEN_W-1:0] mag;
  logic [FRAC_BITS:0]   num;
  logic [DIV_NUM_W-1:0] dividend;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] quotient;
  logic [CROSS_W-1:0]   div_value;

  assign div_axis = axis_t'(cmd.div_sel[DIV_SEL_W-1:1]);

  always_comb begin
    unique case (div_axis)
      AXIS_X:  begin org = in_reg.origin_x; dir = in_reg.dir_x; end
      AXIS_Y:  begin org = in_reg.origin_y; dir = in_reg.dir_y; end
      AXIS_Z:  begin org = in_reg.origin_z; dir = in_reg.dir_z; end
      default: begin org = in_reg.origin_z; dir = in_reg.dir_z; end
    endcase
  end

  assign mag = dir[DIR_W-1] ? (~dir + 1'b1) : dir;

  always_comb begin
    if (!cmd.div_sel[0]) begin
      num = ONE;
    end else if (dir[DIR_W-1]) begin
      num = {1'b0, org[FRAC_BITS-1:0]};
    end else begin
      num = ONE - {1'b0, org[FRAC_BITS-1:0]};
    end
  end

  assign dividend  = {num, {DIR_FRAC_BITS{1'b0}}};
  assign div_value = (mag == '0) ? CROSS_INF : CROSS_W'(quotient);

  vrts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (mag),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---- advance: axis choice, reach check, step ----
  logic                 x_lt_y, x_lt_z, y_lt_z;
  axis_t                axis;
  logic [CROSS_W-1:0]   t;
  logic [CROSS_W-1:0]   span;
  logic [CROSS_W-1:0]   limit;
  logic                 beyond;
  logic [CROSS_W:0]     sum;
  logic [CROSS_W-1:0]   cross_acc;
  logic [CELL_W-1:0]    cell_new;
  logic [CELL_W-1:0]    step_cell [3];
  face_t                face;

  assign x_lt_y = next_cross[AXIS_X] < next_cross[AXIS_Y];
  assign x_lt_z = next_cross[AXIS_X] < next_cross[AXIS_Z];
  assign y_lt_z = next_cross[AXIS_Y] < next_cross[AXIS_Z];

  always_comb begin
    if (x_lt_y) begin
      axis = x_lt_z ? AXIS_X : AXIS_Z;
    end else begin
      axis = y_lt_z ? AXIS_Y : AXIS_Z;
    end
  end

  assign t      = next_cross[axis];
  assign span   = cell_span[axis];
  assign limit  = CROSS_W'({reach_limit, {FRAC_BITS{1'b0}}});
  assign beyond = (t == CROSS_INF) || (t > limit);

  assign sum       = {1'b0, t} + {1'b0, span};
  assign cross_acc = ((t == CROSS_INF) || (sum >= {1'b0, CROSS_INF})) ?
                     CROSS_INF : sum[CROSS_W-1:0];

  assign cell_new = cur_cell[axis] + {{(CELL_W-2){step_sign[axis][1]}}, step_sign[axis]};

  always_comb begin
    step_cell[AXIS_X] = cur_cell[AXIS_X];
    step_cell[AXIS_Y] = cur_cell[AXIS_Y];
    step_cell[AXIS_Z] = cur_cell[AXIS_Z];
    step_cell[axis]   = cell_new;
    unique case (axis)
      AXIS_X:  face = step_sign[AXIS_X][1] ? FACE_RIGHT : FACE_LEFT;
      AXIS_Y:  face = step_sign[AXIS_Y][1] ? FACE_UP : FACE_DOWN;
      default: face = step_sign[AXIS_Z][1] ? FACE_FRONT : FACE_BACK;
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_limit <= REACH_RESET;
    end else if (cfg_wen) begin
      reach_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cur_cell[i]   <= '0;
        next_cross[i] <= CROSS_INF;
        cell_span[i]  <= CROSS_INF;
        step_sign[i]  <= '0;
      end
      finished <= 1'b1;
    end else begin
      if (cmd.div_write) begin
        if (cmd.div_sel[0]) begin
          next_cross[div_axis] <= div_value;
        end else begin
          cell_span[div_axis] <= div_value;
        end
      end
      if (cmd.report) begin
        cur_cell[AXIS_X] <= in_reg.origin_x[FRAC_BITS +: CELL_W];
        cur_cell[AXIS_Y] <= in_reg.origin_y[FRAC_BITS +: CELL_W];
        cur_cell[AXIS_Z] <= in_reg.origin_z[FRAC_BITS +: CELL_W];
        step_sign[AXIS_X] <= (in_reg.dir_x == '0) ? 2'b00 :
                             (in_reg.dir_x[DIR_W-1] ? 2'b11 : 2'b01);
        step_sign[AXIS_Y] <= (in_reg.dir_y == '0) ? 2'b00 :
                             (in_reg.dir_y[DIR_W-1] ? 2'b11 : 2'b01);
        step_sign[AXIS_Z] <= (in_reg.dir_z == '0) ? 2'b00 :
                             (in_reg.dir_z[DIR_W-1] ? 2'b11 : 2'b01);
        finished <= 1'b0;
      end
      if (cmd.step && !finished) begin
        if (beyond) begin
          finished <= 1'b1;
        end else begin
          cur_cell[axis]   <= cell_new;
          next_cross[axis] <= cross_acc;
        end
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step || cmd.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_data.cell_x       <= in_reg.origin_x[FRAC_BITS +: CELL_W];
      out_data.cell_y       <= in_reg.origin_y[FRAC_BITS +: CELL_W];
      out_data.cell_z       <= in_reg.origin_z[FRAC_BITS +: CELL_W];
      out_data.entered_face <= FACE_NONE;
      out_data.out_of_range <= 1'b0;
    end else if (cmd.step) begin
      if (finished || beyond) begin
        out_data.cell_x       <= cur_cell[AXIS_X];
        out_data.cell_y       <= cur_cell[AXIS_Y];
        out_data.cell_z       <= cur_cell[AXIS_Z];
        out_data.entered_face <= FACE_NONE;
        out_data.out_of_range <= 1'b1;
      end else begin
        out_data.cell_x       <= step_cell[AXIS_X];
        out_data.cell_y       <= step_cell[AXIS_Y];
        out_data.cell_z       <= step_cell[AXIS_Z];
        out_data.entered_face <= face;
        out_data.out_of_range <= 1'b0;
      end
    end
  end

  assign status.in_is_start = (in_data.command == CMD_START);
  assign status.out_free    = !out_valid || out_ready;
  assign status.div_done    = div_done;

  `VRTS_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.step || cmd.report, !out_valid || out_ready, "result overwritten before taken")
  `VRTS_ASSERT_NEXT(a_finished_sticks, clk, rst, cmd.step && finished, finished, "finished ray resumed on advance")
  `VRTS_ASSERT_NEXT(a_cross_grows, clk, rst, cmd.step, next_cross[AXIS_X] >= $past(next_cross[AXIS_X]), "crossing decreased on advance")

endmodule

// ===== src/voxel_ray_traversal_stepper.sv =====
// ---------------------------------------------------------------------------
// voxel_ray_traversal_stepper
// Grid walk of a ray through unit voxels in three axes, one cell per item.
// ---------------------------------------------------------------------------
// A start item (command 0) takes a Q16.16 origin and a Q2.14 unit direction
// and returns the start cell with entered_face none. Each advance item
// (command 1) moves one cell along the axis whose next boundary crossing is
// nearest (ties go to z, then y) and returns the new cell and the face it
// entered through; once that crossing is infinite or lies past reach_limit
// whole units, out_of_range is set and the ray stays finished until the next
// start. An advance passes through the accepting state and a step state
// that waits until the output register is free; its result is registered
// when the step is taken. A start runs six divisions (span and first
// crossing per axis) one after another on a single bit-serial divider
// between intake and report. One item is in work at a time; a finished
// result sits in an output register so the next item can be taken while
// it waits. reach_limit resets to 500; the user is bound to write it via
// cfg_wen/cfg_wdata only while the block is idle, which it does not enforce.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_ray_traversal_stepper import vrts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  // reach limit register
  input  logic               cfg_wen,
  input  logic [REACH_W-1:0] cfg_wdata
);

  // controller and datapath talk only through these two bundles
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: intake, division steps, output hand-off
  vrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // ray state, shared divider, step logic and result register
  vrts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
